// ===== design/assert_macros.svh =====
// Assertion shorthands shared by the design modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ipc_pkg.sv =====
package ipc_pkg;

   // Field widths
   localparam int ADC_W   = 12;
   localparam int STAMP_W = 16;
   localparam int DIST_W  = 12;
   localparam int CLASS_W = 3;
   localparam int LIMIT_W = 8;
   localparam int DEN_W   = 16;
   localparam int PROD_W  = LIMIT_W + STAMP_W;

   // 16 * 4800 * 4095 / 60 scaled numerator, denominator 11*adc - 1365
   localparam logic [22:0] DIST_NUM   = 23'd5241600;
   localparam logic [DEN_W-1:0] DEN_OFFSET = 16'd1365;
   localparam logic [DEN_W-1:0] DEN_SCALE  = 16'd11;
   localparam logic [DIST_W-1:0] DIST_MAX  = 12'd4095;

   // Readings up to this value give a denominator below 1280, so the
   // quotient would reach 4096 or the denominator is not positive.
   localparam logic [ADC_W-1:0] SAT_ADC_MAX = 12'd240;

   // Quotient bits produced by the divider
   localparam int DIV_STEPS = DIST_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Band limits in 1/16 cm
   localparam logic [DIST_W-1:0] BAND_10CM = 12'd160;
   localparam logic [DIST_W-1:0] BAND_20CM = 12'd320;
   localparam logic [DIST_W-1:0] BAND_30CM = 12'd480;
   localparam logic [DIST_W-1:0] BAND_50CM = 12'd800;
   localparam logic [DIST_W-1:0] BAND_80CM = 12'd1280;

   // Categories
   localparam logic [CLASS_W-1:0] CLS_OUT   = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_FAR   = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_MID   = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_NEAR  = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_CLOSE = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// ===== design/ir_proximity_classifier.sv =====
// Infrared proximity classifier. Each req_ transfer carries a 12-bit sensor
// reading and a 16-bit timer stamp (4096 ticks per second); each produces one
// rsp_ transfer with the distance in 1/16 cm (saturated at 4095) and a
// category from 0 (out of range) to 4 (very close). Each item passes through
// capture, forming the divisor and the speed threshold product, the
// bit-serial restoring divider for the twelve quotient bits, and
// classification. A new item is accepted once the previous result has been
// written into the output register, where it may still wait to transfer;
// classification holds while an earlier result has not yet transferred.
// The speed limit (cm/s, reset 10) is written through the csr_ port; the
// user must write it only while idle, as the block itself does not enforce
// this.
module ir_proximity_classifier (
   input  logic        clock,
   input  logic        reset,
   // csr: speed_limit[7:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req tdata: adc_sample[11:0], stamp[27:12], zero[31:28]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp tdata: distance[11:0], proximity_class[14:12], zero[15]
   output logic [15:0] rsp_tdata
);
   import ipc_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [DIST_W-1:0]  distance;
   logic [CLASS_W-1:0] proximity_class;

   assign csr_ready = 1'b1;

   ipc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ipc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_valid & csr_ready),
      .csr_wdata       (csr_wdata),
      .adc_sample      (req_tdata[ADC_W-1:0]),
      .stamp           (req_tdata[ADC_W+STAMP_W-1:ADC_W]),
      .distance        (distance),
      .proximity_class (proximity_class)
   );

   assign rsp_tdata = {1'b0, proximity_class, distance};

endmodule

// ===== design/ipc_datapath.sv =====
module ipc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ipc_pkg::cmd_type           cmd,
   output ipc_pkg::status_type        status,
   input  logic                       csr_write,
   input  logic [ipc_pkg::LIMIT_W-1:0] csr_wdata,
   input  logic [ipc_pkg::ADC_W-1:0]  adc_sample,
   input  logic [ipc_pkg::STAMP_W-1:0] stamp,
   output logic [ipc_pkg::DIST_W-1:0] distance,
   output logic [ipc_pkg::CLASS_W-1:0] proximity_class
);
   import ipc_pkg::*;

   `include "assert_macros.svh"

   logic [LIMIT_W-1:0] speed_limit_ff;
   logic [DIST_W-1:0]  last_distance_ff;
   logic [STAMP_W-1:0] last_stamp_ff;

   logic [ADC_W-1:0]   adc_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               sat_ff;
   logic [STAMP_W-1:0] dt_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DIST_W-1:0]  num_ff;
   logic [DIST_W-1:0]  quot_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DIST_W-1:0]  distance_ff;
   logic [CLASS_W-1:0] class_ff;

   logic [STAMP_W-1:0] dt_in;
   logic [DEN_W:0]     trial;
   logic               take;
   logic [DIST_W-1:0]  dist_in;
   logic [DIST_W:0]    drop;
   logic               fast;
   logic [CLASS_W-1:0] class_in;

   function automatic logic [CLASS_W-1:0] classify(input logic [DIST_W-1:0] d,
                                                   input logic is_fast);
      logic [CLASS_W-1:0] c;
      priority if (d < BAND_10CM || d > BAND_80CM) c = CLS_OUT;
      else if (d <= BAND_20CM) c = CLS_CLOSE;
      else if (d < BAND_30CM)  c = is_fast ? CLS_CLOSE : CLS_NEAR;
      else if (d < BAND_50CM)  c = is_fast ? CLS_NEAR : CLS_MID;
      else                     c = is_fast ? CLS_MID : CLS_FAR;
      return c;
   endfunction

   // Speed limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= LIMIT_W'(10);
      end else if (csr_write) begin
         speed_limit_ff <= csr_wdata;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         adc_ff   <= adc_sample;
         stamp_ff <= stamp;
      end
   end

   // Prepare denominator, elapsed ticks and the speed threshold product
   assign dt_in = stamp_ff - last_stamp_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         den_ff  <= DEN_W'(adc_ff) * DEN_SCALE - DEN_OFFSET;
         sat_ff  <= (adc_ff <= SAT_ADC_MAX);
         dt_ff   <= dt_in;
         prod_ff <= PROD_W'(speed_limit_ff) * PROD_W'(dt_in);
      end
   end

   // Restoring divider, one quotient bit a cycle
   assign trial = {rem_ff, num_ff[DIST_W-1]};
   assign take  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rem_ff  <= DEN_W'(DIST_NUM[22:DIST_W]);
         num_ff  <= DIST_NUM[DIST_W-1:0];
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_ff  <= {num_ff[DIST_W-2:0], 1'b0};
         quot_ff <= {quot_ff[DIST_W-2:0], take};
      end
   end

   // Step counter for the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.prep) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   assign status.div_done = (step_ff == STEP_W'(DIV_STEPS - 1));

   // Saturate, compare approach speed and classify
   assign dist_in  = sat_ff ? DIST_MAX : quot_ff;
   assign drop     = {1'b0, last_distance_ff} - {1'b0, dist_in};
   assign fast     = (dt_ff != '0) && !drop[DIST_W]
                     && (PROD_W'({drop[DIST_W-1:0], 8'd0}) > prod_ff);
   assign class_in = classify(dist_in, fast);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         distance_ff <= dist_in;
         class_ff    <= class_in;
      end
   end

   // Previous distance and stamp
   always_ff @(posedge clock) begin
      if (reset) begin
         last_distance_ff <= '0;
         last_stamp_ff    <= '0;
      end else if (cmd.finish) begin
         last_distance_ff <= dist_in;
         last_stamp_ff    <= stamp_ff;
      end
   end

   assign distance        = distance_ff;
   assign proximity_class = class_ff;

   `ASSERT_NEXT(a_prep_clears_step, cmd.prep, step_ff == '0, "divider step not cleared")
   `ASSERT_ALWAYS(a_rem_below_den, !cmd.div_step || sat_ff || rem_ff < den_ff,
                  "divider remainder out of range")

endmodule

// ===== design/ipc_controller.sv =====
module ipc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output ipc_pkg::cmd_type     cmd,
   input  ipc_pkg::status_type  status
);
   import ipc_pkg::*;

   `include "assert_macros.svh"

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      out_free;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

   `ASSERT_ALWAYS(a_finish_free, !cmd.finish || out_free, "result overwritten before transfer")
   `ASSERT_NEXT(a_accept_prep, req_tvalid && req_tready, state_ff == ST_PREP,
                "accepted item not prepared")
   `ASSERT_NEXT(a_div_end, state_ff == ST_DIV && status.div_done, state_ff == ST_FINISH,
                "divider end missed")

endmodule
